>>> rtl/core/luhn_pkg.sv
// luhn_pkg: types, constants and digit helpers for the luhn card number check unit
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package luhn_pkg;

   typedef logic [3:0] digit_type;
   typedef logic [4:0] count_type;

   localparam digit_type DIGIT_MAX  = 4'd9;
   localparam count_type COUNT_MAX  = 5'd31;
   localparam count_type LEN_SHORT  = 5'd15;
   localparam count_type LEN_LONG   = 5'd16;
   localparam digit_type LEAD_THREE = 4'd3;
   localparam digit_type LEAD_FOUR  = 4'd4;
   localparam digit_type LEAD_FIVE  = 4'd5;
   localparam digit_type SECOND_A   = 4'd4;
   localparam digit_type SECOND_B   = 4'd7;
   localparam digit_type SECOND_LO  = 4'd1;
   localparam digit_type SECOND_HI  = 4'd5;

   typedef enum logic [1:0] {
      BRAND_NONE  = 2'd0,
      BRAND_LEAD3 = 2'd1,
      BRAND_LEAD4 = 2'd2,
      BRAND_LEAD5 = 2'd3
   } brand_type;

   // input register contents
   typedef struct packed {
      logic      valid;
      digit_type digit;
      logic      last_digit;
   } stage_type;

   // one finished result, as handed to the output register
   typedef struct packed {
      logic      valid;
      logic      luhn_ok;
      brand_type brand;
      count_type digit_count;
   } result_type;

   function automatic digit_type clamp_digit(input digit_type d);
      return (d > DIGIT_MAX) ? DIGIT_MAX : d;
   endfunction

   // luhn doubling: 2d, minus nine when that reaches two digits
   function automatic digit_type double_digit(input digit_type d);
      logic [4:0] t;
      t = {d, 1'b0};
      if (t >= 5'd10) begin
         t = t - 5'd9;
      end
      return t[3:0];
   endfunction

   // both operands are at most nine
   function automatic digit_type add_mod10(input digit_type a, input digit_type b);
      logic [4:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 5'd10) begin
         s = s - 5'd10;
      end
      return s[3:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/luhn_if.sv
// luhn_req_if and luhn_rsp_if: valid/ready channels of the luhn card number check unit
// depends on luhn_pkg for the payload types
`default_nettype none

interface luhn_req_if;
   logic                valid;
   logic                ready;
   luhn_pkg::digit_type digit;
   logic                last_digit;

   modport source (output valid, output digit, output last_digit, input ready);
   modport sink   (input valid, input digit, input last_digit, output ready);
endinterface

interface luhn_rsp_if;
   logic                valid;
   logic                ready;
   logic                luhn_ok;
   logic [1:0]          brand;
   luhn_pkg::count_type digit_count;

   modport source (output valid, output luhn_ok, output brand, output digit_count,
                   input ready);
   modport sink   (input valid, input luhn_ok, input brand, input digit_count,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/core/luhn_card_number_check_unit.sv
// luhn_card_number_check_unit: top level of the luhn mod-10 card number checker
// depends on luhn_pkg, luhn_if, luhn_in_stage, luhn_accum and luhn_out_stage
//
//   channel    direction  payload                          beat
//   req_chan   in         digit[3:0], last_digit           one digit, msd first
//   rsp_chan   out        luhn_ok, brand[1:0], digit_count one result per number
//
// one digit is taken every cycle unless a final digit is stalled; a final digit beat is held in the input
// register until the result register has room, and its result is then registered there for rsp_chan
// the input register and the result register each hold one beat, so a stalled result
// blocks only a final digit behind it, other digits keep flowing into the sums
// synchronous reset clears the sums, count, leading digits and both valid flags
`default_nettype none

module luhn_card_number_check_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   luhn_req_if.sink    req_chan,
   luhn_rsp_if.source  rsp_chan
);
   import luhn_pkg::*;

   stage_type  stage;
   result_type result;
   logic       advance;
   logic       out_free;

   luhn_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .out_free (out_free),
      .stage    (stage),
      .advance  (advance)
   );

   luhn_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .advance (advance),
      .result  (result)
   );

   luhn_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .rsp_chan (rsp_chan),
      .out_free (out_free)
   );

endmodule

`default_nettype wire

>>> rtl/core/luhn_in_stage.sv
// luhn_in_stage: input register for digit beats, with the stall decision
// depends on luhn_pkg and luhn_req_if
`default_nettype none

module luhn_in_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   luhn_req_if.sink             req_chan,
   input  wire logic            out_free,
   output luhn_pkg::stage_type  stage,
   output logic                 advance
);
   import luhn_pkg::*;

   stage_type stage_ff, stage_in;
   logic      take;

   // a final digit may only move on when the output register has room
   assign advance        = stage_ff.valid && (!stage_ff.last_digit || out_free);
   assign req_chan.ready = !stage_ff.valid || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      stage_in = stage_ff;
      if (take) begin
         stage_in.valid      = 1'b1;
         stage_in.digit      = req_chan.digit;
         stage_in.last_digit = req_chan.last_digit;
      end else if (advance) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.digit      <= stage_in.digit;
      stage_ff.last_digit <= stage_in.last_digit;
   end

   assign stage = stage_ff;

endmodule

`default_nettype wire

>>> rtl/core/luhn_accum.sv
// luhn_accum: running luhn sums, digit count and leading digits, plus brand decode
// depends on luhn_pkg
`default_nettype none

module luhn_accum (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire luhn_pkg::stage_type  stage,
   input  wire logic                 advance,
   output luhn_pkg::result_type      result
);
   import luhn_pkg::*;

   digit_type sum_even_ff, sum_even_in;
   digit_type sum_odd_ff, sum_odd_in;
   count_type count_ff, count_in;
   digit_type lead_ff, lead_in;
   digit_type second_ff, second_in;

   digit_type d, dd, sel;
   logic      ok;
   brand_type brand;

   always_comb begin
      d  = clamp_digit(stage.digit);
      dd = double_digit(d);

      sum_even_in = sum_even_ff;
      sum_odd_in  = sum_odd_ff;
      count_in    = count_ff;
      lead_in     = lead_ff;
      second_in   = second_ff;

      // leading zeros leave everything untouched
      if (!(count_ff == '0 && d == '0)) begin
         if (!count_ff[0]) begin
            sum_even_in = add_mod10(sum_even_ff, dd);
            sum_odd_in  = add_mod10(sum_odd_ff, d);
         end else begin
            sum_even_in = add_mod10(sum_even_ff, d);
            sum_odd_in  = add_mod10(sum_odd_ff, dd);
         end
         if (count_ff == 5'd0) begin
            lead_in = d;
         end else if (count_ff == 5'd1) begin
            second_in = d;
         end
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 5'd1;
         end
      end

      sel = count_in[0] ? sum_odd_in : sum_even_in;
      ok  = (count_in != '0) && (sel == '0);

      brand = BRAND_NONE;
      if (ok) begin
         if (count_in == LEN_SHORT && lead_in == LEAD_THREE &&
             (second_in == SECOND_A || second_in == SECOND_B)) begin
            brand = BRAND_LEAD3;
         end else if (count_in == LEN_LONG && lead_in == LEAD_FOUR) begin
            brand = BRAND_LEAD4;
         end else if (count_in == LEN_LONG && lead_in == LEAD_FIVE &&
                      second_in >= SECOND_LO && second_in <= SECOND_HI) begin
            brand = BRAND_LEAD5;
         end
      end

      result.valid       = advance && stage.last_digit;
      result.luhn_ok     = ok;
      result.brand       = brand;
      result.digit_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_even_ff <= '0;
         sum_odd_ff  <= '0;
         count_ff    <= '0;
         lead_ff     <= '0;
         second_ff   <= '0;
      end else if (advance) begin
         if (stage.last_digit) begin
            // number finished: start clean for the next one
            sum_even_ff <= '0;
            sum_odd_ff  <= '0;
            count_ff    <= '0;
            lead_ff     <= '0;
            second_ff   <= '0;
         end else begin
            sum_even_ff <= sum_even_in;
            sum_odd_ff  <= sum_odd_in;
            count_ff    <= count_in;
            lead_ff     <= lead_in;
            second_ff   <= second_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/luhn_out_stage.sv
// luhn_out_stage: result register driving the response channel
// depends on luhn_pkg and luhn_rsp_if
`default_nettype none

module luhn_out_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire luhn_pkg::result_type  result,
   luhn_rsp_if.source                 rsp_chan,
   output logic                       out_free
);
   import luhn_pkg::*;

   result_type rsp_ff, rsp_in;

   assign out_free = !rsp_ff.valid || rsp_chan.ready;

   always_comb begin
      rsp_in = rsp_ff;
      if (result.valid) begin
         rsp_in = result;
      end else if (rsp_chan.ready) begin
         rsp_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.luhn_ok     <= rsp_in.luhn_ok;
      rsp_ff.brand       <= rsp_in.brand;
      rsp_ff.digit_count <= rsp_in.digit_count;
   end

   assign rsp_chan.valid       = rsp_ff.valid;
   assign rsp_chan.luhn_ok     = rsp_ff.luhn_ok;
   assign rsp_chan.brand       = 2'(rsp_ff.brand);
   assign rsp_chan.digit_count = rsp_ff.digit_count;

endmodule

`default_nettype wire
